// ===== rtl/toml_string_unescape_unit_macros.svh =====
// Assertion macros shared by the string unescape RTL.
`ifndef TOML_STRING_UNESCAPE_UNIT_MACROS_SVH
`define TOML_STRING_UNESCAPE_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Expression must never be true outside reset.
`define TSU_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== rtl/tsu_pkg.sv =====
// Types, codes and helper functions shared by the string unescape RTL.
`timescale 1ns / 1ps

package tsu_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_BODY,
		PH_ESC,
		PH_HEX
	} phase_t;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NEWLINE   = 3'd1;
	localparam logic [2:0] ERR_BAD_HEX   = 3'd2;
	localparam logic [2:0] ERR_EARLY_END = 3'd3;
	localparam logic [2:0] ERR_CODEPOINT = 3'd4;

	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_UC_U   = 8'h55;

	localparam logic [31:0] CP_MAX = 32'h0010_FFFF;

	localparam int MAX_RESULTS = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic [2:0] err;
	} res_t;

	// One accepted beat worth of results, count from 0 to MAX_RESULTS.
	typedef struct packed {
		logic [2:0]                   count;
		res_t [MAX_RESULTS-1:0]       res;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic res_t res_byte(input logic [7:0] d);
		res_t r;
		r.data  = d;
		r.valid = 1'b1;
		r.done  = 1'b0;
		r.err   = ERR_NONE;
		return r;
	endfunction

	function automatic res_t res_err(input logic [2:0] e);
		res_t r;
		r.data  = 8'h00;
		r.valid = 1'b0;
		r.done  = 1'b0;
		r.err   = e;
		return r;
	endfunction

	function automatic res_t res_done();
		res_t r;
		r.data  = 8'h00;
		r.valid = 1'b0;
		r.done  = 1'b1;
		r.err   = ERR_NONE;
		return r;
	endfunction

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'h0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.val = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			h.val = c[3:0] + 4'd9;
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

// ===== rtl/tsu_front.sv =====
// Front end: accepts body beats, tracks string state and builds result groups.
`timescale 1ns / 1ps
`include "toml_string_unescape_unit_macros.svh"

module tsu_front import tsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic       full,
	input  logic [7:0] in_byte,
	input  logic [1:0] kind,
	input  logic       start_req,
	input  logic       content_end,
	output logic       push,
	output cmd_t       cmd
);

	phase_t      phase_q, ph_d;
	logic [1:0]  kind_q, kind_d;
	logic [1:0]  pq_q, pq_d;
	logic        pcr_q, pcr_d;
	logic        hex_long_q, hl_d;
	logic [2:0]  hex_count_q, hc_d;
	logic [27:0] cp_q, cp_d;

	logic        accept;
	logic        run_body;
	logic [7:0]  q_ch;
	logic [3:0]  hcn;
	logic [31:0] cpn;
	hex_t        hx;

	assign ready  = !full;
	assign accept = valid && ready;
	assign push   = accept && (cmd.count != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			kind_q      <= 2'd0;
			pq_q        <= 2'd0;
			pcr_q       <= 1'b0;
			hex_long_q  <= 1'b0;
			hex_count_q <= 3'd0;
			cp_q        <= 28'd0;
		end else if (accept) begin
			phase_q     <= ph_d;
			kind_q      <= kind_d;
			pq_q        <= pq_d;
			pcr_q       <= pcr_d;
			hex_long_q  <= hl_d;
			hex_count_q <= hc_d;
			cp_q        <= cp_d;
		end
	end

	always_comb begin
		ph_d     = phase_q;
		kind_d   = kind_q;
		pq_d     = pq_q;
		pcr_d    = pcr_q;
		hl_d     = hex_long_q;
		hc_d     = hex_count_q;
		cp_d     = cp_q;
		cmd      = '0;
		run_body = 1'b0;
		hcn      = 4'd0;
		cpn      = 32'd0;
		hx       = hex_decode(in_byte);

		// a new string drops whatever was open
		if (start_req) begin
			kind_d = kind;
			pq_d   = 2'd0;
			pcr_d  = 1'b0;
			hc_d   = 3'd0;
			hl_d   = 1'b0;
			cp_d   = 28'd0;
			ph_d   = kind[0] ? PH_LEAD : PH_BODY;
		end

		q_ch = kind_d[1] ? CH_SQUOTE : CH_DQUOTE;

		if (content_end) begin
			unique case (ph_d)
				PH_LEAD, PH_BODY: begin
					// flush held bytes ahead of the error
					if (pcr_d) begin
						cmd.res[cmd.count[1:0]] = res_byte(CH_CR);
						cmd.count = cmd.count + 3'd1;
					end
					if (pq_d != 2'd0) begin
						cmd.res[cmd.count[1:0]] = res_byte(q_ch);
						cmd.count = cmd.count + 3'd1;
					end
					if (pq_d == 2'd2) begin
						cmd.res[cmd.count[1:0]] = res_byte(q_ch);
						cmd.count = cmd.count + 3'd1;
					end
					cmd.res[cmd.count[1:0]] = res_err(ERR_EARLY_END);
					cmd.count = cmd.count + 3'd1;
					ph_d  = PH_IDLE;
					pq_d  = 2'd0;
					pcr_d = 1'b0;
				end
				PH_ESC: begin
					cmd.res[0] = res_byte(CH_BSLASH);
					cmd.res[1] = res_err(ERR_EARLY_END);
					cmd.count  = 3'd2;
					ph_d  = PH_IDLE;
					pq_d  = 2'd0;
					pcr_d = 1'b0;
				end
				PH_HEX: begin
					cmd.res[0] = res_err(ERR_EARLY_END);
					cmd.count  = 3'd1;
					ph_d  = PH_IDLE;
					pq_d  = 2'd0;
					pcr_d = 1'b0;
				end
				default: begin
				end
			endcase
		end else begin
			unique case (ph_d)
				PH_LEAD: begin
					if (pcr_d) begin
						pcr_d = 1'b0;
						ph_d  = PH_BODY;
						// a CR not followed by LF is content
						if (in_byte != CH_LF) begin
							cmd.res[0] = res_byte(CH_CR);
							cmd.count  = 3'd1;
							run_body   = 1'b1;
						end
					end else if (in_byte == CH_LF) begin
						ph_d = PH_BODY;
					end else if (in_byte == CH_CR) begin
						pcr_d = 1'b1;
					end else begin
						ph_d     = PH_BODY;
						run_body = 1'b1;
					end
				end
				PH_BODY: begin
					run_body = 1'b1;
				end
				PH_ESC: begin
					ph_d = PH_BODY;
					unique case (in_byte)
						CH_LC_B: begin
							cmd.res[0] = res_byte(CH_BS);
							cmd.count  = 3'd1;
						end
						CH_LC_T: begin
							cmd.res[0] = res_byte(CH_TAB);
							cmd.count  = 3'd1;
						end
						CH_LC_N: begin
							cmd.res[0] = res_byte(CH_LF);
							cmd.count  = 3'd1;
						end
						CH_LC_F: begin
							cmd.res[0] = res_byte(CH_FF);
							cmd.count  = 3'd1;
						end
						CH_LC_R: begin
							cmd.res[0] = res_byte(CH_CR);
							cmd.count  = 3'd1;
						end
						CH_LC_U, CH_UC_U: begin
							ph_d = PH_HEX;
							hl_d = (in_byte == CH_UC_U);
							hc_d = 3'd0;
							cp_d = 28'd0;
						end
						default: begin
							cmd.res[0] = res_byte(in_byte);
							cmd.count  = 3'd1;
						end
					endcase
				end
				PH_HEX: begin
					if (!hx.ok) begin
						cmd.res[0] = res_err(ERR_BAD_HEX);
						cmd.count  = 3'd1;
						ph_d  = PH_IDLE;
						pq_d  = 2'd0;
						pcr_d = 1'b0;
					end else begin
						cpn  = {cp_d, hx.val};
						hcn  = {1'b0, hc_d} + 4'd1;
						cp_d = cpn[27:0];
						hc_d = hcn[2:0];
						if (hl_d ? (hcn == 4'd8) : (hcn == 4'd4)) begin
							ph_d = PH_BODY;
							hc_d = 3'd0;
							if (cpn > CP_MAX) begin
								cmd.res[0] = res_err(ERR_CODEPOINT);
								cmd.count  = 3'd1;
								ph_d  = PH_IDLE;
								pq_d  = 2'd0;
								pcr_d = 1'b0;
							end else if (cpn < 32'h80) begin
								cmd.res[0] = res_byte(cpn[7:0]);
								cmd.count  = 3'd1;
							end else if (cpn < 32'h800) begin
								cmd.res[0] = res_byte({3'b110, cpn[10:6]});
								cmd.res[1] = res_byte({2'b10, cpn[5:0]});
								cmd.count  = 3'd2;
							end else if (cpn < 32'h1_0000) begin
								cmd.res[0] = res_byte({4'b1110, cpn[15:12]});
								cmd.res[1] = res_byte({2'b10, cpn[11:6]});
								cmd.res[2] = res_byte({2'b10, cpn[5:0]});
								cmd.count  = 3'd3;
							end else begin
								cmd.res[0] = res_byte({5'b11110, cpn[20:18]});
								cmd.res[1] = res_byte({2'b10, cpn[17:12]});
								cmd.res[2] = res_byte({2'b10, cpn[11:6]});
								cmd.res[3] = res_byte({2'b10, cpn[5:0]});
								cmd.count  = 3'd4;
							end
						end
					end
				end
				default: begin
				end
			endcase

			if (run_body) begin
				if (kind_d[0]) begin
					// multi-line: hold quotes until a close or another byte
					if (in_byte == q_ch) begin
						if (pq_d == 2'd2) begin
							cmd.res[cmd.count[1:0]] = res_done();
							cmd.count = cmd.count + 3'd1;
							ph_d  = PH_IDLE;
							pq_d  = 2'd0;
							pcr_d = 1'b0;
						end else begin
							pq_d = pq_d + 2'd1;
						end
					end else begin
						if (pq_d != 2'd0) begin
							cmd.res[cmd.count[1:0]] = res_byte(q_ch);
							cmd.count = cmd.count + 3'd1;
						end
						if (pq_d == 2'd2) begin
							cmd.res[cmd.count[1:0]] = res_byte(q_ch);
							cmd.count = cmd.count + 3'd1;
						end
						pq_d = 2'd0;
						if (!kind_d[1] && in_byte == CH_BSLASH) begin
							ph_d = PH_ESC;
						end else begin
							cmd.res[cmd.count[1:0]] = res_byte(in_byte);
							cmd.count = cmd.count + 3'd1;
						end
					end
				end else begin
					if (in_byte == CH_LF) begin
						cmd.res[cmd.count[1:0]] = res_err(ERR_NEWLINE);
						cmd.count = cmd.count + 3'd1;
						ph_d  = PH_IDLE;
						pq_d  = 2'd0;
						pcr_d = 1'b0;
					end else begin
						if (pcr_d) begin
							cmd.res[cmd.count[1:0]] = res_byte(CH_CR);
							cmd.count = cmd.count + 3'd1;
						end
						pcr_d = 1'b0;
						if (in_byte == CH_CR) begin
							pcr_d = 1'b1;
						end else if (in_byte == q_ch) begin
							cmd.res[cmd.count[1:0]] = res_done();
							cmd.count = cmd.count + 3'd1;
							ph_d = PH_IDLE;
						end else if (!kind_d[1] && in_byte == CH_BSLASH) begin
							ph_d = PH_ESC;
						end else begin
							cmd.res[cmd.count[1:0]] = res_byte(in_byte);
							cmd.count = cmd.count + 3'd1;
						end
					end
				end
			end
		end
	end

	`TSU_ASSERT(a_hex_short_count, (phase_q == PH_HEX) && !hex_long_q |-> (hex_count_q < 3'd4), "short hex run counted past four digits")

endmodule

// ===== rtl/tsu_queue.sv =====
// Short queue of result groups between the front and back ends.
`timescale 1ns / 1ps
`include "toml_string_unescape_unit_macros.svh"

module tsu_queue import tsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr,
	input  logic pop,
	output cmd_t rd,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`TSU_ASSERT(a_push_not_full, push |-> !full, "group pushed into a full queue")
	`TSU_ASSERT(a_cnt_grows, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue fill lost a push")

endmodule

// ===== rtl/tsu_back.sv =====
// Back end: walks the head group and sends its results one beat at a time.
`timescale 1ns / 1ps
`include "toml_string_unescape_unit_macros.svh"

module tsu_back import tsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [4:0] m_tuser,   // byte_valid, string_done, error_code[2:0]
	output logic       m_tlast
);

	logic [1:0] idx_q;
	res_t       cur;
	logic       beat;
	logic       at_end;

	assign cur      = head.res[idx_q];
	assign at_end   = ({1'b0, idx_q} == head.count - 3'd1);
	assign m_tvalid = !empty;
	assign m_tdata  = cur.data;
	assign m_tuser  = {cur.err, cur.done, cur.valid};
	assign m_tlast  = at_end;
	assign beat     = m_tvalid && m_tready;
	assign pop      = beat && at_end;

	// advance within the group, rewind when it retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (beat) begin
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	`TSU_ASSERT(a_head_count, !empty |-> (head.count != 3'd0) && (head.count <= 3'd4), "queued group has a bad result count")
	`TSU_ASSERT_NEVER(a_idx_range, !empty && ({1'b0, idx_q} >= head.count), "result index ran past its group")

endmodule

// ===== rtl/toml_string_unescape_unit.sv =====
// Top level of the TOML string body decoder with stream ports.
// Path: each taken group is registered in the queue and offered on m_tvalid from the head.
// Throughput: one input beat per cycle while the group queue has room; a beat that yields
// k results holds the output for k output beats, and QUEUE_DEPTH groups absorb such bursts.
// Reset: arst_n clears the string state to idle and empties the queue at once.
`timescale 1ns / 1ps

module toml_string_unescape_unit import tsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic [3:0] s_tuser,   // kind[1:0], start_req, content_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [4:0] m_tuser,   // byte_valid, string_done, error_code[2:0]
	output logic       m_tlast
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	cmd_t wr_cmd;
	cmd_t head;

	tsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid       (s_tvalid),
		.ready       (s_tready),
		.full        (full),
		.in_byte     (s_tdata),
		.kind        (s_tuser[1:0]),
		.start_req   (s_tuser[2]),
		.content_end (s_tuser[3]),
		.push        (push),
		.cmd         (wr_cmd)
	);

	tsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr     (wr_cmd),
		.pop    (pop),
		.rd     (head),
		.full   (full),
		.empty  (empty)
	);

	tsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
